>>> hw/rtl/rblh_pkg.sv
// shared constants, types and helpers for the rgb brightness / luminance histogram
// depends on nothing
package rblh_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int FINE_BINS   = 1024;
   localparam int COLOUR_BINS = 256;

   localparam int FINE_W   = $clog2(FINE_BINS);
   localparam int COLOUR_W = $clog2(COLOUR_BINS);
   localparam int OUT_W    = 24;
   localparam int BIN_W    = 10;
   localparam int SUM_W    = 10;

   // luminance weights, 16-bit fraction
   localparam logic [15:0] W_RED   = 16'd13933;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_BLUE  = 16'd4732;
   localparam int LUM_W = 25;

   // brightness: floor(sum * FINE_BINS / 765) by exact reciprocal
   localparam int BRI_SH = 20 + FINE_W;
   localparam longint unsigned BRI_M = ((64'd1 << BRI_SH) + 64'd764) / 64'd765;
   localparam int BRI_MW  = $clog2(BRI_M + 1);
   localparam int BRI_PW  = SUM_W + BRI_MW;
   localparam int BRI_SHR = BRI_SH - FINE_W;

   // luminance: floor((S >> (16 - FINE_W)) / 255) by exact reciprocal
   localparam int LUM_DROP = 16 - FINE_W;
   localparam int LUM_T_W  = 8 + FINE_W;
   localparam int LUM_SH   = 16 + FINE_W;
   localparam longint unsigned LUM_M = ((64'd1 << LUM_SH) + 64'd254) / 64'd255;
   localparam int LUM_MW = $clog2(LUM_M + 1);
   localparam int LUM_PW = LUM_T_W + LUM_MW;

   localparam logic MODE_ACC  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [2:0] {
      HIST_RED   = 3'd0,
      HIST_GREEN = 3'd1,
      HIST_BLUE  = 3'd2,
      HIST_BRI   = 3'd3,
      HIST_LUM   = 3'd4
   } hist_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FETCH,
      ST_WRITE,
      ST_LOOKUP,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [FINE_W-1:0] bri;
      logic [FINE_W-1:0] lum;
   } idx_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      r = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
      return r;
   endfunction

   function automatic logic [FINE_W-1:0] clamp_fine(input logic [FINE_W:0] q);
      logic [FINE_W-1:0] r;
      r = (q > (FINE_W+1)'(FINE_BINS - 1)) ? FINE_W'(FINE_BINS - 1) : q[FINE_W-1:0];
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] out_fmt(input logic [COUNT_BITS-1:0] c);
      logic [47:0] w;
      w = 48'(c);
      return w[OUT_W-1:0];
   endfunction

endpackage

>>> hw/rtl/rblh_ram.sv
// single-port-write, single-port-read synchronous ram, registered read data
// depends on nothing
module rblh_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rblh_bin_calc.sv
// two-stage pipeline computing brightness and luminance bin indices of a pixel
// depends on rblh_pkg
module rblh_bin_calc (
   input  logic            clock,
   input  logic [7:0]      red,
   input  logic [7:0]      green,
   input  logic [7:0]      blue,
   output rblh_pkg::idx_type idx
);
   import rblh_pkg::*;

   logic [SUM_W-1:0]   sum;
   logic [LUM_W-1:0]   lum_sum;
   logic [BRI_PW-1:0]  bri_prod_in, bri_prod_ff;
   logic [LUM_T_W-1:0] lum_t_in, lum_t_ff;
   logic [LUM_PW-1:0]  lum_prod;
   idx_type            idx_in, idx_ff;

   // stage 1: channel sum and weighted sum, brightness reciprocal product
   always_comb begin
      sum         = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
      lum_sum     = LUM_W'(red) * LUM_W'(W_RED) + LUM_W'(green) * LUM_W'(W_GREEN)
                  + LUM_W'(blue) * LUM_W'(W_BLUE);
      bri_prod_in = BRI_PW'(sum) * BRI_PW'(BRI_M);
      lum_t_in    = LUM_T_W'(lum_sum >> LUM_DROP);
   end

   always_ff @(posedge clock) begin
      bri_prod_ff <= bri_prod_in;
      lum_t_ff    <= lum_t_in;
   end

   // stage 2: luminance reciprocal product, clamp both
   always_comb begin
      lum_prod   = LUM_PW'(lum_t_ff) * LUM_PW'(LUM_M);
      idx_in.bri = clamp_fine((FINE_W+1)'(bri_prod_ff >> BRI_SHR));
      idx_in.lum = clamp_fine((FINE_W+1)'(lum_prod >> LUM_SH));
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign idx = idx_ff;

endmodule

>>> hw/rtl/rgb_brightness_luminance_histogram.sv
// rgb brightness / luminance histogram: five saturating histograms in rams
// accumulate: busy from the accepting edge through states mul, div, fetch and write (index
//   pipeline of 2 stages, then ram read and write back); no new pixel is taken until idle
// read: states lookup then respond, rsp_valid high in respond; no new read is taken until
//   idle again, and the receiver cannot stall results
// reset: sweep clears all bins, busy high until the sweep of FINE_BINS (1024) addresses ends
module rgb_brightness_luminance_histogram (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [2:0]                req_hist_select,
   input  logic [9:0]                req_bin_index,
   output logic                      rsp_valid,
   output logic [rblh_pkg::OUT_W-1:0] rsp_bin_count
);
   import rblh_pkg::*;

   state_type state_ff, state_in;
   logic [FINE_W-1:0] clr_ff, clr_in;
   logic [7:0]        red_ff, green_ff, blue_ff;
   logic [2:0]        sel_ff;
   logic [BIN_W-1:0]  bin_ff;
   logic              accept;
   idx_type           idx;

   logic                  we;
   logic [COLOUR_W-1:0]   c_rd_addr, r_addr, g_addr, b_addr;
   logic [FINE_W-1:0]     f_rd_addr, bri_addr, lum_addr;
   logic [COUNT_BITS-1:0] r_rd, g_rd, b_rd, bri_rd, lum_rd;
   logic [COUNT_BITS-1:0] r_wd, g_wd, b_wd, bri_wd, lum_wd;
   logic [COUNT_BITS-1:0] pick;
   logic                  in_range;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         sel_ff   <= req_hist_select;
         bin_ff   <= req_bin_index;
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      we        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == FINE_W'(FINE_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = (req_mode == MODE_READ) ? ST_LOOKUP : ST_MUL;
            end
         end
         ST_MUL:     state_in = ST_DIV;
         ST_DIV:     state_in = ST_FETCH;
         ST_FETCH:   state_in = ST_WRITE;
         ST_WRITE: begin
            we       = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LOOKUP:  state_in = ST_RESPOND;
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // addresses stay put from fetch through write back
   always_comb begin
      c_rd_addr = COLOUR_W'(bin_ff);
      f_rd_addr = FINE_W'(bin_ff);
      if (state_ff == ST_CLEAR) begin
         r_addr   = COLOUR_W'(clr_ff);
         g_addr   = COLOUR_W'(clr_ff);
         b_addr   = COLOUR_W'(clr_ff);
         bri_addr = clr_ff;
         lum_addr = clr_ff;
      end else if (state_ff == ST_LOOKUP || state_ff == ST_RESPOND) begin
         r_addr   = c_rd_addr;
         g_addr   = c_rd_addr;
         b_addr   = c_rd_addr;
         bri_addr = f_rd_addr;
         lum_addr = f_rd_addr;
      end else begin
         r_addr   = COLOUR_W'(red_ff);
         g_addr   = COLOUR_W'(green_ff);
         b_addr   = COLOUR_W'(blue_ff);
         bri_addr = idx.bri;
         lum_addr = idx.lum;
      end
      if (state_ff == ST_CLEAR) begin
         r_wd   = '0;
         g_wd   = '0;
         b_wd   = '0;
         bri_wd = '0;
         lum_wd = '0;
      end else begin
         r_wd   = sat_inc(r_rd);
         g_wd   = sat_inc(g_rd);
         b_wd   = sat_inc(b_rd);
         bri_wd = sat_inc(bri_rd);
         lum_wd = sat_inc(lum_rd);
      end
   end

   rblh_bin_calc u_bin_calc (
      .clock (clock),
      .red   (red_ff),
      .green (green_ff),
      .blue  (blue_ff),
      .idx   (idx)
   );

   rblh_ram #(.DEPTH(COLOUR_BINS), .WIDTH(COUNT_BITS)) u_red_ram (
      .clock (clock), .wr_en (we), .wr_addr (r_addr), .wr_data (r_wd),
      .rd_addr (r_addr), .rd_data (r_rd)
   );

   rblh_ram #(.DEPTH(COLOUR_BINS), .WIDTH(COUNT_BITS)) u_green_ram (
      .clock (clock), .wr_en (we), .wr_addr (g_addr), .wr_data (g_wd),
      .rd_addr (g_addr), .rd_data (g_rd)
   );

   rblh_ram #(.DEPTH(COLOUR_BINS), .WIDTH(COUNT_BITS)) u_blue_ram (
      .clock (clock), .wr_en (we), .wr_addr (b_addr), .wr_data (b_wd),
      .rd_addr (b_addr), .rd_data (b_rd)
   );

   rblh_ram #(.DEPTH(FINE_BINS), .WIDTH(COUNT_BITS)) u_bri_ram (
      .clock (clock), .wr_en (we), .wr_addr (bri_addr), .wr_data (bri_wd),
      .rd_addr (bri_addr), .rd_data (bri_rd)
   );

   rblh_ram #(.DEPTH(FINE_BINS), .WIDTH(COUNT_BITS)) u_lum_ram (
      .clock (clock), .wr_en (we), .wr_addr (lum_addr), .wr_data (lum_wd),
      .rd_addr (lum_addr), .rd_data (lum_rd)
   );

   // read result select, out-of-range bins and unknown selectors give zero
   always_comb begin
      in_range = 1'b0;
      pick     = '0;
      case (sel_ff)
         HIST_RED: begin
            in_range = (13'(bin_ff) < 13'(COLOUR_BINS));
            pick     = r_rd;
         end
         HIST_GREEN: begin
            in_range = (13'(bin_ff) < 13'(COLOUR_BINS));
            pick     = g_rd;
         end
         HIST_BLUE: begin
            in_range = (13'(bin_ff) < 13'(COLOUR_BINS));
            pick     = b_rd;
         end
         HIST_BRI: begin
            in_range = (13'(bin_ff) < 13'(FINE_BINS));
            pick     = bri_rd;
         end
         HIST_LUM: begin
            in_range = (13'(bin_ff) < 13'(FINE_BINS));
            pick     = lum_rd;
         end
         default: begin
            in_range = 1'b0;
            pick     = '0;
         end
      endcase
      rsp_bin_count = in_range ? out_fmt(pick) : '0;
   end

   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOKUP))
      else $error("result strobe without a preceding lookup");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after a transfer");

   a_idle_entry: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> ($past(state_ff == ST_WRITE) || $past(state_ff == ST_RESPOND)
                       || $past(state_ff == ST_CLEAR)))
      else $error("busy dropped outside the end of an item or the clear sweep");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (busy && !rsp_valid))
      else $error("activity during the clear sweep");

endmodule

>>> verif/tb_rgb_brightness_luminance_histogram.sv
// self-checking testbench for rgb_brightness_luminance_histogram: pixel and read transfers
// checked against a histogram tally class; depends on rblh_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_rgb_brightness_luminance_histogram;
   import rblh_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_RANDOM  = 500;

   class histogram_tally;
      bit [COUNT_BITS-1:0] colour_bins [3][COLOUR_BINS];
      bit [COUNT_BITS-1:0] fine_bins [2][FINE_BINS];
      bit [OUT_W-1:0]      expected_counts [$];
      int                  mismatches;
      int                  pixels;
      int                  reads;
      int                  nonzero_reads;

      function int unsigned bri_bin(bit [7:0] r, bit [7:0] g, bit [7:0] b);
         bit [63:0] q;
         q = (64'(r) + 64'(g) + 64'(b)) * 64'(FINE_BINS) / 64'd765;
         return (q > 64'(FINE_BINS - 1)) ? FINE_BINS - 1 : int'(q);
      endfunction

      function int unsigned lum_bin(bit [7:0] r, bit [7:0] g, bit [7:0] b);
         bit [63:0] s;
         bit [63:0] q;
         s = 64'(W_RED) * 64'(r) + 64'(W_GREEN) * 64'(g) + 64'(W_BLUE) * 64'(b);
         q = s * 64'(FINE_BINS) / (64'd255 * 64'd65536);
         return (q > 64'(FINE_BINS - 1)) ? FINE_BINS - 1 : int'(q);
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction

      function void note_transfer(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [2:0] sel, logic [9:0] bin);
         int unsigned    bi;
         int unsigned    li;
         bit [OUT_W-1:0] val;
         if (mode == MODE_ACC) begin
            bi = bri_bin(r, g, b);
            li = lum_bin(r, g, b);
            // counters hold at all ones
            if (colour_bins[0][r] != '1) colour_bins[0][r]++;
            if (colour_bins[1][g] != '1) colour_bins[1][g]++;
            if (colour_bins[2][b] != '1) colour_bins[2][b]++;
            if (fine_bins[0][bi] != '1) fine_bins[0][bi]++;
            if (fine_bins[1][li] != '1) fine_bins[1][li]++;
            pixels++;
         end else begin
            val = '0;
            case (sel)
               HIST_RED, HIST_GREEN, HIST_BLUE: begin
                  if (bin < COLOUR_BINS) val = OUT_W'(colour_bins[int'(sel)][bin]);
               end
               HIST_BRI: begin
                  if (bin < FINE_BINS) val = OUT_W'(fine_bins[0][bin]);
               end
               HIST_LUM: begin
                  if (bin < FINE_BINS) val = OUT_W'(fine_bins[1][bin]);
               end
               default: val = '0;
            endcase
            expected_counts.push_back(val);
            reads++;
            if (val != 0) nonzero_reads++;
         end
      endfunction

      function void check_count(logic [OUT_W-1:0] actual);
         bit [OUT_W-1:0] exp_count;
         if (expected_counts.size() == 0) begin
            $error("bin_count: no result expected, actual %0d", actual);
            mismatches++;
         end else begin
            exp_count = expected_counts.pop_front();
            if (actual !== exp_count) begin
               $error("bin_count: expected %0d, actual %0d", exp_count, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_mode;
   logic [7:0]       req_red;
   logic [7:0]       req_green;
   logic [7:0]       req_blue;
   logic [2:0]       req_hist_select;
   logic [9:0]       req_bin_index;
   logic             rsp_valid;
   logic [OUT_W-1:0] rsp_bin_count;

   histogram_tally tally = new();
   int             cycles;
   logic [23:0]    seen_pixels [$];
   logic [23:0]    palette [8];

   rgb_brightness_luminance_histogram dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_hist_select(req_hist_select),
      .req_bin_index(req_bin_index),
      .rsp_valid(rsp_valid),
      .rsp_bin_count(rsp_bin_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result first, then the transfer accepted at the same edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) tally.check_count(rsp_bin_count);
      if (!reset && start && !busy)
         tally.note_transfer(req_mode, req_red, req_green, req_blue, req_hist_select,
                             req_bin_index);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[rgb_brightness_luminance_histogram] ERROR");
         $finish;
      end
   end

   task automatic issue(input logic mode, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b, input logic [2:0] sel, input logic [9:0] bin);
      start           <= 1'b1;
      req_mode        <= mode;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_hist_select <= sel;
      req_bin_index   <= bin;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (mode == MODE_ACC) seen_pixels.push_back({r, g, b});
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait so the last transfer is noted, then until the block is idle and no result is pending
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || tally.pending() > 0) @(posedge clock);
   endtask

   task automatic random_item();
      logic [23:0] px;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // pixel: palette, extremes or anything
         case ($urandom_range(0, 3))
            0, 1: px = palette[$urandom_range(0, 7)];
            2: px = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                     {8{$urandom_range(0, 1) == 1}}};
            default: px = 24'($urandom);
         endcase
         issue(MODE_ACC, px[23:16], px[15:8], px[7:0], 3'($urandom), 10'($urandom));
      end else if (pick < 85 && seen_pixels.size() > 0) begin
         // read a bin that a seen pixel landed in
         px = seen_pixels[$urandom_range(0, seen_pixels.size() - 1)];
         case ($urandom_range(0, 4))
            0: issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), HIST_RED,
                     10'(px[23:16]));
            1: issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), HIST_GREEN,
                     10'(px[15:8]));
            2: issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), HIST_BLUE,
                     10'(px[7:0]));
            3: issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), HIST_BRI,
                     10'(tally.bri_bin(px[23:16], px[15:8], px[7:0])));
            default: issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), HIST_LUM,
                           10'(tally.lum_bin(px[23:16], px[15:8], px[7:0])));
         endcase
      end else begin
         issue(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
               10'($urandom));
      end
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      cycles          <= 0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_mode        <= MODE_ACC;
      req_red         <= '0;
      req_green       <= '0;
      req_blue        <= '0;
      req_hist_select <= HIST_RED;
      req_bin_index   <= '0;
      foreach (palette[k]) palette[k] = 24'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared bins, extremes, white clamp, out of range and unknown selectors
      issue(MODE_READ, '1, '1, '1, HIST_RED, '0);
      issue(MODE_READ, '0, '0, '0, HIST_LUM, '1);
      issue(MODE_ACC, '0, '0, '0, '1, '1);
      issue(MODE_ACC, '1, '1, '1, HIST_RED, '0);
      issue(MODE_ACC, '1, '0, '0, HIST_LUM, '1);
      issue(MODE_ACC, '0, '1, '0, HIST_BRI, '0);
      issue(MODE_ACC, '0, '0, '1, HIST_BLUE, '1);
      issue(MODE_ACC, '1, '1, '1, '0, '0);
      idle_for(3);
      issue(MODE_READ, '0, '0, '0, HIST_RED, '0);
      issue(MODE_READ, '0, '0, '0, HIST_RED, 10'd255);
      issue(MODE_READ, '0, '0, '0, HIST_GREEN, 10'd255);
      issue(MODE_READ, '0, '0, '0, HIST_BLUE, '0);
      issue(MODE_READ, '0, '0, '0, HIST_BRI, '0);
      issue(MODE_READ, '0, '0, '0, HIST_BRI, '1);
      issue(MODE_READ, '0, '0, '0, HIST_LUM, '0);
      issue(MODE_READ, '1, '1, '1, HIST_LUM, '1);
      issue(MODE_READ, '0, '0, '0, HIST_BRI, 10'(tally.bri_bin('1, '0, '0)));
      issue(MODE_READ, '0, '0, '0, HIST_LUM, 10'(tally.lum_bin('0, '1, '0)));
      issue(MODE_READ, '0, '0, '0, HIST_RED, 10'd256);
      issue(MODE_READ, '0, '0, '0, HIST_BLUE, '1);
      for (int s = int'(HIST_LUM) + 1; s < 8; s++) issue(MODE_READ, '0, '0, '0, 3'(s), '0);
      issue(MODE_READ, '0, '0, '0, '1, '1);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         random_item();
         if (i == NUM_RANDOM / 2) drain();
         else if ((i % 100) >= 25) idle_for(pick_gap());
      end

      drain();
      repeat (16) @(posedge clock);

      $display("covered %0d pixel transfers and %0d bin reads, %0d of them nonzero",
               tally.pixels, tally.reads, tally.nonzero_reads);
      $display("white clamp, out of range bins and unused selectors included");
      if (tally.mismatches == 0 && tally.pending() == 0) begin
         $display("[rgb_brightness_luminance_histogram] OK");
      end else begin
         $display("[rgb_brightness_luminance_histogram] ERROR");
      end
      $finish;
   end

endmodule
